// ===== src/bgr_pkg.sv =====
package bgr_pkg;

    // Field widths of the stream payloads
    localparam int NODE_FIELD_W = 5;
    localparam int ACTION_W     = 2;
    localparam int S_TDATA_W    = 16;  // node_a, node_b, occupied_flag, zero fill
    localparam int M_TDATA_W    = 16;  // reached_node, came_from, zero fill

    // Configuration register
    localparam int               CFG_W     = 6;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;
    localparam int               CNT_W     = 7;   // effective node count, at most NODES

    // Default sizing
    localparam int DEF_NODES       = 32;
    localparam int DEF_QUEUE_DEPTH = 2;

    // Input action codes
    localparam logic [ACTION_W-1:0] ACT_CONNECT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_OCCUPY  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd2;

    // Command kinds handed from front to back
    localparam logic [1:0] CMD_CONNECT = 2'd0;
    localparam logic [1:0] CMD_OCCUPY  = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;  // query whose start is out of range

    typedef struct packed {
        logic [1:0]              kind;
        logic [NODE_FIELD_W-1:0] node_a;
        logic [NODE_FIELD_W-1:0] node_b;
        logic                    flag;
    } cmd_t;

endpackage

// ===== src/bgr_ram.sv =====
module bgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/bgr_queue.sv =====
module bgr_queue #(
    parameter int DEPTH = bgr_pkg::DEF_QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bgr_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          pop_valid,
    output bgr_pkg::cmd_t pop_cmd,
    input  logic          pop
);
    import bgr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    cmd_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_QW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_QW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/bgr_front.sv =====
module bgr_front #(
    parameter int NODES = bgr_pkg::DEF_NODES
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bgr_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [bgr_pkg::ACTION_W-1:0]       s_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bgr_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               q_full,
    output logic                               q_push,
    output bgr_pkg::cmd_t                      q_cmd,
    output logic [bgr_pkg::CNT_W-1:0]          node_count
);
    import bgr_pkg::*;

    logic [CFG_W-1:0]        nodes_in_use_reg, nodes_in_use_next;
    logic [CNT_W-1:0]        cfg_wide;
    logic [NODE_FIELD_W-1:0] field_a, field_b;
    logic                    a_ok, b_ok, accept;

    assign cfg_ready = 1'b1;

    always_comb begin
        nodes_in_use_next = nodes_in_use_reg;
        if (cfg_valid) begin
            nodes_in_use_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nodes_in_use_reg <= CFG_RESET;
        end else begin
            nodes_in_use_reg <= nodes_in_use_next;
        end
    end

    // Clamp the programmed count to the built node count
    assign cfg_wide   = CNT_W'(nodes_in_use_reg);
    assign node_count = (cfg_wide < CNT_W'(NODES)) ? cfg_wide : CNT_W'(NODES);

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign field_a  = s_tdata[NODE_FIELD_W-1:0];
    assign field_b  = s_tdata[2*NODE_FIELD_W-1:NODE_FIELD_W];
    assign a_ok     = CNT_W'(field_a) < node_count;
    assign b_ok     = CNT_W'(field_b) < node_count;

    // Classify; drop out-of-range edits and unknown actions here
    always_comb begin
        q_cmd.node_a = field_a;
        q_cmd.node_b = field_b;
        q_cmd.flag   = s_tdata[2*NODE_FIELD_W];
        q_cmd.kind   = CMD_NONE;
        q_push       = 1'b0;
        case (s_tuser)
            ACT_CONNECT: begin
                q_cmd.kind = CMD_CONNECT;
                q_push     = accept && a_ok && b_ok;
            end
            ACT_OCCUPY: begin
                q_cmd.kind = CMD_OCCUPY;
                q_push     = accept && a_ok;
            end
            ACT_QUERY: begin
                q_cmd.kind = a_ok ? CMD_QUERY : CMD_NONE;
                q_push     = accept;
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/bgr_back.sv =====
module bgr_back #(
    parameter int NODES = bgr_pkg::DEF_NODES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  bgr_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    input  logic [bgr_pkg::CNT_W-1:0]     node_count,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bgr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import bgr_pkg::*;

    localparam int IDX_W = $clog2(NODES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CONN_B = 3'd1;
    localparam logic [2:0] S_CONN_W = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_POP    = 3'd4;

    function automatic logic [NODES-1:0] onehot(input logic [IDX_W-1:0] idx);
        logic [NODES-1:0] v;
        v      = '0;
        v[idx] = 1'b1;
        return v;
    endfunction

    function automatic logic [IDX_W-1:0] lowest_set(input logic [NODES-1:0] m);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

    logic [2:0]              state_reg, state_next;
    logic [IDX_W-1:0]        cur_reg, cur_next;
    logic [IDX_W-1:0]        sp_reg, sp_next;
    logic [IDX_W-1:0]        a_reg, a_next, b_reg, b_next;
    logic [NODES-1:0]        visited_reg, visited_next;
    logic [NODES-1:0]        occ_reg, occ_next;
    logic [NODES-1:0]        row_valid_reg, row_valid_next;
    logic                    valid_q_reg;
    logic                    pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]        pend_node_reg, pend_node_next;
    logic [IDX_W-1:0]        pend_from_reg, pend_from_next;
    logic                    out_valid_reg;
    logic [NODE_FIELD_W-1:0] out_node_reg, out_from_reg;
    logic                    out_found_reg, out_last_reg;

    logic                    out_load;
    logic [NODE_FIELD_W-1:0] load_node, load_from;
    logic                    load_found, load_last;
    logic                    out_free;

    logic                    adj_we;
    logic [IDX_W-1:0]        adj_waddr, adj_raddr;
    logic [NODES-1:0]        adj_wdata, adj_rdata;
    logic                    stk_we;
    logic [IDX_W-1:0]        stk_raddr, stk_rdata;

    logic [NODES-1:0]        inuse, row, cand;
    logic [IDX_W-1:0]        next_idx, cmd_a, cmd_b;

    bgr_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj (
        .aclk  (aclk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    bgr_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (sp_reg),
        .wdata (cur_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    for (genvar g = 0; g < NODES; g++) begin : g_inuse
        assign inuse[g] = CNT_W'(g) < node_count;
    end

    assign cmd_a     = IDX_W'(q_cmd.node_a);
    assign cmd_b     = IDX_W'(q_cmd.node_b);
    assign stk_raddr = sp_reg - IDX_W'(1);
    // Rows never written read as empty
    assign row       = adj_rdata & {NODES{valid_q_reg}};
    assign cand      = row & inuse & ~visited_reg & ~occ_reg;
    assign next_idx  = lowest_set(cand);
    assign out_free  = !out_valid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        sp_next         = sp_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        visited_next    = visited_reg;
        occ_next        = occ_reg;
        row_valid_next  = row_valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_node_next  = pend_node_reg;
        pend_from_next  = pend_from_reg;
        q_pop           = 1'b0;
        adj_we          = 1'b0;
        adj_waddr       = a_reg;
        adj_wdata       = row | onehot(b_reg);
        adj_raddr       = cur_reg;
        stk_we          = 1'b0;
        out_load        = 1'b0;
        load_node       = NODE_FIELD_W'(pend_node_reg);
        load_from       = NODE_FIELD_W'(pend_from_reg);
        load_found      = 1'b1;
        load_last       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    case (q_cmd.kind)
                        CMD_CONNECT: begin
                            q_pop      = 1'b1;
                            a_next     = cmd_a;
                            b_next     = cmd_b;
                            adj_raddr  = cmd_a;
                            state_next = S_CONN_B;
                        end
                        CMD_OCCUPY: begin
                            q_pop           = 1'b1;
                            occ_next[cmd_a] = q_cmd.flag;
                        end
                        CMD_QUERY: begin
                            q_pop        = 1'b1;
                            visited_next = onehot(cmd_a);
                            cur_next     = cmd_a;
                            sp_next      = '0;
                            adj_raddr    = cmd_a;
                            state_next   = S_EVAL;
                        end
                        default: begin
                            // Start out of range: single empty result
                            if (out_free) begin
                                q_pop      = 1'b1;
                                out_load   = 1'b1;
                                load_node  = '0;
                                load_from  = '0;
                                load_found = 1'b0;
                                load_last  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_CONN_B: begin
                // Row a arrives: set bit b, fetch row b
                adj_we                = 1'b1;
                adj_waddr             = a_reg;
                adj_wdata             = row | onehot(b_reg);
                row_valid_next[a_reg] = 1'b1;
                adj_raddr             = b_reg;
                state_next            = S_CONN_W;
            end
            S_CONN_W: begin
                adj_we                = 1'b1;
                adj_waddr             = b_reg;
                adj_wdata             = row | onehot(a_reg);
                row_valid_next[b_reg] = 1'b1;
                state_next            = S_IDLE;
            end
            S_EVAL: begin
                if (cand != '0) begin
                    if (!pend_valid_reg || out_free) begin
                        // Release the held result, hold the new one
                        out_load                = pend_valid_reg;
                        pend_valid_next         = 1'b1;
                        pend_node_next          = next_idx;
                        pend_from_next          = cur_reg;
                        visited_next[next_idx]  = 1'b1;
                        stk_we                  = 1'b1;
                        sp_next                 = sp_reg + IDX_W'(1);
                        cur_next                = next_idx;
                        adj_raddr               = next_idx;
                    end
                end else if (sp_reg != '0) begin
                    sp_next    = sp_reg - IDX_W'(1);
                    state_next = S_POP;
                end else if (out_free) begin
                    out_load        = 1'b1;
                    load_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    if (!pend_valid_reg) begin
                        load_node  = '0;
                        load_from  = '0;
                        load_found = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_POP: begin
                cur_next   = stk_rdata;
                adj_raddr  = stk_rdata;
                state_next = S_EVAL;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            occ_reg        <= '0;
            row_valid_reg  <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            row_valid_reg  <= row_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        sp_reg        <= sp_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        visited_reg   <= visited_next;
        pend_node_reg <= pend_node_next;
        pend_from_reg <= pend_from_next;
        valid_q_reg   <= row_valid_reg[adj_raddr];
        if (out_load) begin
            out_node_reg  <= load_node;
            out_from_reg  <= load_from;
            out_found_reg <= load_found;
            out_last_reg  <= load_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2 * NODE_FIELD_W){1'b0}}, out_from_reg, out_node_reg};
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/blocked_graph_reachability_core.sv =====
// Channel  | Direction | Transaction                 | Fields (lowest bit first)
// s_       | in        | s_tvalid & s_tready         | tdata: node_a, node_b, occupied_flag
//          |           |                             | tuser: action
// m_       | out       | m_tvalid & m_tready         | tdata: reached_node, came_from
//          |           |                             | tuser: found, tlast: last
// cfg_     | in        | cfg_valid & cfg_ready       | cfg_data: nodes_in_use
//
// Steps: a connect reads and rewrites row a, then row b; an occupy or a query with an out-of-range
// start is handled in IDLE; a query proper starts, enters each node, pops the stack on a backtrack
// and finishes, paced by the single read port of the adjacency RAM and the stack RAM read on a backtrack.
// Reset: aresetn low clears row valid bits, occupancy, queue and output; nodes_in_use to 32.
// Stalls: the front keeps accepting into a two-entry command queue while the back works, until it
// is full; a held m_ result stalls only the steps that need the output register.
module blocked_graph_reachability_core #(
    parameter int NODES       = bgr_pkg::DEF_NODES,
    parameter int QUEUE_DEPTH = bgr_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input transactions
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bgr_pkg::S_TDATA_W-1:0] s_tdata,   // [4:0] node_a, [9:5] node_b,
                                                     // [10] occupied_flag
    input  logic [bgr_pkg::ACTION_W-1:0]  s_tuser,   // [1:0] action
    // Result transactions
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bgr_pkg::M_TDATA_W-1:0] m_tdata,   // [4:0] reached_node, [9:5] came_from
    output logic                          m_tuser,   // [0] found
    output logic                          m_tlast,
    // Configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bgr_pkg::CFG_W-1:0]     cfg_data
);
    import bgr_pkg::*;

    // Classified commands between front and back
    logic             q_push, q_full, q_valid, q_pop;
    cmd_t             q_in_cmd, q_out_cmd;
    logic [CNT_W-1:0] node_count;

    // Front: decode the action, range-check against the active count, drop no-ops
    bgr_front #(.NODES(NODES)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_in_cmd),
        .node_count (node_count)
    );

    // Short command queue decoupling the two sides
    bgr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_in_cmd),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_cmd   (q_out_cmd),
        .pop       (q_pop)
    );

    // Back: edge updates, occupancy and the depth-first walk with its output register
    bgr_back #(.NODES(NODES)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_cmd      (q_out_cmd),
        .q_pop      (q_pop),
        .node_count (node_count),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== src/bgr_checker.sv =====
module bgr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bgr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);
    import bgr_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // An empty answer is always the only and final one of its query
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("empty result not final or not zero");

    // A node is never reported as reached from itself
    a_no_self: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[NODE_FIELD_W-1:0] != m_tdata[2*NODE_FIELD_W-1:NODE_FIELD_W])
        else $error("reached node equals its predecessor");

    // No result straight after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind blocked_graph_reachability_core bgr_checker u_bgr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
